FILE: src/ssp_pkg.sv
// Shared constants, types and codes for the sequential servo pulse generator.
package ssp_pkg;

    localparam int CHANNELS     = 8;
    localparam int TICKS_PER_US = 2;
    localparam int GUARD_TICKS  = 8;

    localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W   = 17;
    localparam int SLOT_W  = 4;
    localparam int VAL_W   = 16;
    localparam int PROD_W  = VAL_W + $clog2(TICKS_PER_US + 1);

    localparam logic [SLOT_W-1:0] IDLE_SLOT  = SLOT_W'(8);
    localparam logic [SLOT_W-1:0] CHAN_LIMIT = SLOT_W'(CHANNELS);
    localparam logic [CNT_W-1:0]  GUARD_CNT  = CNT_W'(GUARD_TICKS);

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_WIDTH = 2'd1,
        ACT_MIN   = 2'd2,
        ACT_MAX   = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        REG_PERIOD = 4'd0,
        REG_ENABLE = 4'd1
    } reg_index_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_cur;
        logic [SLOT_W-1:0] slot_next;
        logic              frame_start;
    } timer_status_t;

endpackage

FILE: src/sequential_servo_pulse_generator.sv
// Top level of the sequential servo pulse generator.
// Each transfer is either a timer tick or a write of a channel's width,
// minimum or maximum (in microseconds). Every input transfer yields exactly
// one result transfer: the pin levels, the active slot (8 = all slots done),
// a frame-start flag and a write-ok flag. One transfer is taken per clock
// cycle when the result side keeps up; each item passes through the input
// register and then the execute step that loads the output register.
// The rate is set by the width memory: the width of the running slot is read
// ahead through the registered read port, with the read address taken from
// the next slot index, so each tick finds its slot width ready. Limits are
// prefetched at the incoming channel. All three stores reset to zero through
// per-entry valid bits, so no clearing pass runs after reset.
module sequential_servo_pulse_generator (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [3:0] channel, [19:4] width_us, rest zero
    input  logic [1:0]  s_tuser,   // [1:0] action
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [7:0] pin_levels, [11:8] active_channel,
                                   // [12] frame_start, [13] write_ok, rest zero
);

    // configuration registers
    logic [15:0] period_reg;
    logic [7:0]  enable_reg;

    // input register
    logic                 x_valid_reg;
    ssp_pkg::action_t     x_action_reg;
    logic [3:0]           x_channel_reg;
    logic [15:0]          x_width_reg;

    // output register
    logic        m_valid_reg;
    logic [15:0] m_data_reg;

    logic s_xfer, exec;
    logic is_tick, write_ok;
    logic [ssp_pkg::PROD_W-1:0] prod;
    logic [15:0] ticks, clamped;
    logic [15:0] width_rd, min_rd, max_rd;
    logic [ssp_pkg::CH_W-1:0] width_raddr, lim_raddr, waddr;
    logic [3:0]  lim_ch;
    logic [7:0]  pins;
    ssp_pkg::timer_status_t tstat;

    // config writes; indexes beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= '0;
            enable_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                ssp_pkg::REG_PERIOD: period_reg <= cfg_wdata;
                ssp_pkg::REG_ENABLE: enable_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // handshake: execute when the output register is free or draining
    assign exec     = x_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !x_valid_reg || exec;
    assign s_xfer   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_valid_reg <= 1'b0;
        end else if (s_tready) begin
            x_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            x_action_reg  <= ssp_pkg::action_t'(s_tuser[1:0]);
            x_channel_reg <= s_tdata[3:0];
            x_width_reg   <= s_tdata[19:4];
        end
    end

    // execute step
    assign is_tick  = (x_action_reg == ssp_pkg::ACT_TICK);
    assign write_ok = !is_tick && (x_channel_reg < ssp_pkg::SLOT_W'(ssp_pkg::CHANNELS));
    assign waddr    = x_channel_reg[ssp_pkg::CH_W-1:0];

    always_comb begin
        prod    = ssp_pkg::PROD_W'(x_width_reg) * ssp_pkg::PROD_W'(ssp_pkg::TICKS_PER_US);
        ticks   = (prod > ssp_pkg::PROD_W'(16'hFFFF)) ? 16'hFFFF : prod[15:0];
        // when limits cross, values below the minimum take the minimum, all others the maximum
        if (ticks < min_rd) begin
            clamped = min_rd;
        end else if (ticks > max_rd) begin
            clamped = max_rd;
        end else begin
            clamped = ticks;
        end
    end

    ssp_timer u_timer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (exec && is_tick),
        .period     (period_reg),
        .slot_width (width_rd),
        .status     (tstat)
    );

    // prefetch the width of the slot that the next tick will see
    assign width_raddr = (tstat.slot_next < ssp_pkg::CHAN_LIMIT)
                       ? tstat.slot_next[ssp_pkg::CH_W-1:0] : '0;

    // prefetch limits at the channel of the item held next cycle
    assign lim_ch    = s_xfer ? s_tdata[3:0] : x_channel_reg;
    assign lim_raddr = lim_ch[ssp_pkg::CH_W-1:0];

    ssp_ram #(.DEPTH(ssp_pkg::CHANNELS), .WIDTH(ssp_pkg::VAL_W), .AW(ssp_pkg::CH_W)) u_width_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (exec && write_ok && (x_action_reg == ssp_pkg::ACT_WIDTH)),
        .waddr   (waddr),
        .wdata   (clamped),
        .raddr   (width_raddr),
        .rdata   (width_rd)
    );

    ssp_ram #(.DEPTH(ssp_pkg::CHANNELS), .WIDTH(ssp_pkg::VAL_W), .AW(ssp_pkg::CH_W)) u_min_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (exec && write_ok && (x_action_reg == ssp_pkg::ACT_MIN)),
        .waddr   (waddr),
        .wdata   (ticks),
        .raddr   (lim_raddr),
        .rdata   (min_rd)
    );

    ssp_ram #(.DEPTH(ssp_pkg::CHANNELS), .WIDTH(ssp_pkg::VAL_W), .AW(ssp_pkg::CH_W)) u_max_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (exec && write_ok && (x_action_reg == ssp_pkg::ACT_MAX)),
        .waddr   (waddr),
        .wdata   (ticks),
        .raddr   (lim_raddr),
        .rdata   (max_rd)
    );

    // pin of the slot after this step, under the current enable mask
    always_comb begin
        pins = '0;
        if (tstat.slot_next < ssp_pkg::CHAN_LIMIT && enable_reg[tstat.slot_next[2:0]]) begin
            pins = 8'd1 << tstat.slot_next[2:0];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (exec) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec) begin
            m_data_reg <= {2'b00, write_ok, is_tick && tstat.frame_start,
                           tstat.slot_next, pins};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

FILE: src/ssp_ram.sv
// Small synchronous RAM: one write port, one registered read port, write-through, zero reset.
module ssp_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 16,
    parameter int AW    = 3
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (we) begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // write-through keeps a same-cycle update visible to the next read
    always_ff @(posedge aclk) begin
        if (we && (waddr == raddr)) begin
            rdata_reg <= wdata;
        end else if (!aresetn || !valid_reg[raddr]) begin
            rdata_reg <= '0;
        end else begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/ssp_timer.sv
// Frame and slot counters: advances the slot sequence on each tick, or holds it idle while the period is zero.
module ssp_timer (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         step,
    input  logic [ssp_pkg::VAL_W-1:0]    period,
    input  logic [ssp_pkg::VAL_W-1:0]    slot_width,
    output ssp_pkg::timer_status_t       status
);

    logic [ssp_pkg::CNT_W-1:0]  frame_count_reg, frame_count_next;
    logic [ssp_pkg::CNT_W-1:0]  slot_count_reg, slot_count_next;
    logic [ssp_pkg::SLOT_W-1:0] slot_index_reg, slot_index_next;
    logic [ssp_pkg::CNT_W-1:0]  frame_len, fc_wrapped, fc_inc, slot_len, sc_inc;
    logic                       fstart;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_count_reg <= '0;
            slot_count_reg  <= '0;
            slot_index_reg  <= ssp_pkg::IDLE_SLOT;
        end else begin
            frame_count_reg <= frame_count_next;
            slot_count_reg  <= slot_count_next;
            slot_index_reg  <= slot_index_next;
        end
    end

    always_comb begin
        frame_len  = {1'b0, period} + ssp_pkg::GUARD_CNT;
        fc_wrapped = (frame_count_reg >= frame_len) ? '0 : frame_count_reg;
        fc_inc     = fc_wrapped + ssp_pkg::CNT_W'(1);
        slot_len   = {1'b0, slot_width} + ssp_pkg::GUARD_CNT;
        sc_inc     = slot_count_reg + ssp_pkg::CNT_W'(1);

        frame_count_next = frame_count_reg;
        slot_count_next  = slot_count_reg;
        slot_index_next  = slot_index_reg;
        fstart           = 1'b0;

        if (step) begin
            if (period == '0) begin
                frame_count_next = '0;
                slot_count_next  = '0;
                slot_index_next  = ssp_pkg::IDLE_SLOT;
            end else begin
                if (fc_wrapped == '0) begin
                    fstart          = 1'b1;
                    slot_index_next = '0;
                    slot_count_next = '0;
                end else if (slot_index_reg < ssp_pkg::CHAN_LIMIT) begin
                    if (sc_inc >= slot_len) begin
                        slot_count_next = '0;
                        slot_index_next = slot_index_reg + ssp_pkg::SLOT_W'(1);
                        if (slot_index_next >= ssp_pkg::CHAN_LIMIT) begin
                            slot_index_next = ssp_pkg::IDLE_SLOT;
                        end
                    end else begin
                        slot_count_next = sc_inc;
                    end
                end else begin
                    slot_index_next = ssp_pkg::IDLE_SLOT;
                end
                frame_count_next = (fc_inc >= frame_len) ? '0 : fc_inc;
            end
        end

        status.slot_cur    = slot_index_reg;
        status.slot_next   = slot_index_next;
        status.frame_start = fstart;
    end

endmodule

FILE: src/ssp_checker.sv
// Port-level checks on the result stream of the servo pulse generator.
module ssp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[11:8] <= 4'd8)
        else $error("active channel out of range");

    a_one_pin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot0(m_tdata[7:0]))
        else $error("more than one pin high");

    a_pin_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[7:0] != 8'd0) |-> m_tdata[7:0] == (8'd1 << m_tdata[11:8]))
        else $error("high pin does not match active slot");

    a_frame_start: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[12] |-> (m_tdata[11:8] == 4'd0) && !m_tdata[13])
        else $error("frame start without slot zero or on a write");

endmodule

bind sequential_servo_pulse_generator ssp_checker u_ssp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
